/* rtl/rc_throttle_motor_drive_top_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef RC_THROTTLE_MOTOR_DRIVE_TOP_DEFINES_SVH
`define RC_THROTTLE_MOTOR_DRIVE_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define RCTMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rctmd check failed");

// Condition implies consequence in the next cycle.
`define RCTMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rctmd check failed");

`endif

/* rtl/rctmd_pkg.sv */
package rctmd_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned WIDTH_W    = 13;
  localparam int unsigned PWM_W      = 15;
  localparam int unsigned BSUM_W     = 14;
  localparam int unsigned BLINK_W    = 6;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned CFG_AW     = 5;
  localparam int unsigned REG_IDX_W  = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_THROTTLE_CENTER   = 3'd0;
  localparam reg_idx_t REG_DRIVE_DEADBAND    = 3'd1;
  localparam reg_idx_t REG_PWM_LIMIT         = 3'd2;
  localparam reg_idx_t REG_LIGHT_ON_WIDTH    = 3'd3;
  localparam reg_idx_t REG_LIGHT_VALID_WIDTH = 3'd4;
  localparam reg_idx_t REG_BATTERY_HIGH_SUM  = 3'd5;
  localparam reg_idx_t REG_BATTERY_OK_SUM    = 3'd6;
  localparam reg_idx_t REG_BATTERY_LOW_SUM   = 3'd7;

  localparam logic [WIDTH_W-1:0] RST_THROTTLE_CENTER   = 13'd1500;
  localparam logic [PWM_W-1:0]   RST_DRIVE_DEADBAND    = 15'd4200;
  localparam logic [PWM_W-1:0]   RST_PWM_LIMIT         = 15'd12000;
  localparam logic [WIDTH_W-1:0] RST_LIGHT_ON_WIDTH    = 13'd1300;
  localparam logic [WIDTH_W-1:0] RST_LIGHT_VALID_WIDTH = 13'd800;
  localparam logic [BSUM_W-1:0]  RST_BATTERY_HIGH_SUM  = 14'd4498;
  localparam logic [BSUM_W-1:0]  RST_BATTERY_OK_SUM    = 14'd4037;
  localparam logic [BSUM_W-1:0]  RST_BATTERY_LOW_SUM   = 14'd3748;

  typedef struct packed {
    logic [SAMPLE_W-1:0] battery_sample;
    logic [WIDTH_W-1:0]  throttle_width;
    logic [WIDTH_W-1:0]  light_width;
  } in_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_on_time;
    logic             drive_forward;
    logic             drive_reverse;
    logic             lamp_on;
    logic             green_indicator;
    logic             red_indicator;
    logic             supply_low_flag;
  } out_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] throttle_center;
    logic [PWM_W-1:0]   drive_deadband;
    logic [PWM_W-1:0]   pwm_limit;
    logic [WIDTH_W-1:0] light_on_width;
    logic [WIDTH_W-1:0] light_valid_width;
    logic [BSUM_W-1:0]  battery_high_sum;
    logic [BSUM_W-1:0]  battery_ok_sum;
    logic [BSUM_W-1:0]  battery_low_sum;
  } cfg_t;

  typedef struct packed {
    logic green;
    logic red;
    logic supply_low;
  } bat_stat_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic             fwd;
    logic             rev;
    logic             lights;
  } drv_res_t;

endpackage

/* rtl/rctmd_cfg.sv */
module rctmd_cfg
  import rctmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_THROTTLE_CENTER:   cfg_nxt.throttle_center   = pwdata[WIDTH_W-1:0];
        REG_DRIVE_DEADBAND:    cfg_nxt.drive_deadband    = pwdata[PWM_W-1:0];
        REG_PWM_LIMIT:         cfg_nxt.pwm_limit         = pwdata[PWM_W-1:0];
        REG_LIGHT_ON_WIDTH:    cfg_nxt.light_on_width    = pwdata[WIDTH_W-1:0];
        REG_LIGHT_VALID_WIDTH: cfg_nxt.light_valid_width = pwdata[WIDTH_W-1:0];
        REG_BATTERY_HIGH_SUM:  cfg_nxt.battery_high_sum  = pwdata[BSUM_W-1:0];
        REG_BATTERY_OK_SUM:    cfg_nxt.battery_ok_sum    = pwdata[BSUM_W-1:0];
        REG_BATTERY_LOW_SUM:   cfg_nxt.battery_low_sum   = pwdata[BSUM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THROTTLE_CENTER:   prdata = CFG_DW'(cfg_r.throttle_center);
      REG_DRIVE_DEADBAND:    prdata = CFG_DW'(cfg_r.drive_deadband);
      REG_PWM_LIMIT:         prdata = CFG_DW'(cfg_r.pwm_limit);
      REG_LIGHT_ON_WIDTH:    prdata = CFG_DW'(cfg_r.light_on_width);
      REG_LIGHT_VALID_WIDTH: prdata = CFG_DW'(cfg_r.light_valid_width);
      REG_BATTERY_HIGH_SUM:  prdata = CFG_DW'(cfg_r.battery_high_sum);
      REG_BATTERY_OK_SUM:    prdata = CFG_DW'(cfg_r.battery_ok_sum);
      REG_BATTERY_LOW_SUM:   prdata = CFG_DW'(cfg_r.battery_low_sum);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_center   <= RST_THROTTLE_CENTER;
      cfg_r.drive_deadband    <= RST_DRIVE_DEADBAND;
      cfg_r.pwm_limit         <= RST_PWM_LIMIT;
      cfg_r.light_on_width    <= RST_LIGHT_ON_WIDTH;
      cfg_r.light_valid_width <= RST_LIGHT_VALID_WIDTH;
      cfg_r.battery_high_sum  <= RST_BATTERY_HIGH_SUM;
      cfg_r.battery_ok_sum    <= RST_BATTERY_OK_SUM;
      cfg_r.battery_low_sum   <= RST_BATTERY_LOW_SUM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/rctmd_battery.sv */
module rctmd_battery
  import rctmd_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHECK = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output bat_stat_t           stat
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_CHECK + 1);

  logic [BSUM_W-1:0] sum_r;
  logic [BSUM_W-1:0] sum_nxt;
  logic [BSUM_W-1:0] sum_add;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  bat_stat_t         stat_r;
  bat_stat_t         stat_nxt;

  assign sum_add = sum_r + BSUM_W'(sample);
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    sum_nxt  = sum_add;
    cnt_nxt  = cnt_inc;
    stat_nxt = stat_r;
    // A full group is classified with the highest band checked first.
    if (cnt_inc == CNT_W'(SAMPLES_PER_CHECK)) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      priority if (sum_add > cfg.battery_high_sum) begin
        stat_nxt.green      = ~stat_r.green;
        stat_nxt.red        = 1'b0;
        stat_nxt.supply_low = 1'b0;
      end else if (sum_add > cfg.battery_ok_sum) begin
        stat_nxt.green      = 1'b1;
        stat_nxt.red        = 1'b0;
        stat_nxt.supply_low = 1'b0;
      end else if (sum_add > cfg.battery_low_sum) begin
        stat_nxt.green = 1'b0;
        stat_nxt.red   = 1'b1;
      end else begin
        stat_nxt.green      = 1'b0;
        stat_nxt.red        = ~stat_r.red;
        stat_nxt.supply_low = 1'b1;
      end
    end
  end

  // The updated status applies to the frame that caused it.
  assign stat = stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      stat_r <= '0;
    end else if (fire) begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      stat_r <= stat_nxt;
    end
  end

endmodule

/* rtl/rctmd_drive.sv */
module rctmd_drive
  import rctmd_pkg::*;
#(
  parameter int unsigned GAIN_SHIFT = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [WIDTH_W-1:0] throttle_width,
  input  logic [WIDTH_W-1:0] light_width,
  input  logic               supply_low,
  input  cfg_t               cfg,
  output drv_res_t           res
);

  localparam int unsigned SHIFT_W = WIDTH_W + GAIN_SHIFT;
  localparam int unsigned MAG_W   = (SHIFT_W > PWM_W) ? SHIFT_W : PWM_W;

  logic [PWM_W-1:0]   held_r;
  logic [PWM_W-1:0]   held_nxt;
  logic [BLINK_W-1:0] blink_r;
  logic [BLINK_W-1:0] blink_nxt;
  logic               ahead;
  logic               active;
  logic [WIDTH_W-1:0] diff;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   lim;
  logic [PWM_W-1:0]   pwm_sat;
  logic               light_ok;

  assign ahead  = throttle_width > cfg.throttle_center;
  assign diff   = ahead ? (throttle_width - cfg.throttle_center)
                        : (cfg.throttle_center - throttle_width);
  assign mag    = MAG_W'(diff) << GAIN_SHIFT;
  assign lim    = MAG_W'(cfg.pwm_limit);
  assign pwm_sat = (mag > lim) ? cfg.pwm_limit : mag[PWM_W-1:0];
  assign active = (throttle_width != '0) && !supply_low;
  assign held_nxt = active ? pwm_sat : held_r;

  assign light_ok  = light_width > cfg.light_valid_width;
  assign blink_nxt = light_ok ? blink_r : (blink_r + 1'b1);

  always_comb begin
    res.pwm    = held_nxt;
    res.fwd    = active && (pwm_sat > cfg.drive_deadband) && ahead;
    res.rev    = active && (pwm_sat > cfg.drive_deadband) && !ahead;
    // An invalid light channel blinks once per counter wrap.
    res.lights = light_ok ? (light_width > cfg.light_on_width) : (blink_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      blink_r <= '0;
    end else if (fire) begin
      held_r  <= held_nxt;
      blink_r <= blink_nxt;
    end
  end

endmodule

/* rtl/rc_throttle_motor_drive_top.sv */
// RC throttle motor drive.
// Input channel (in_valid, in_stall, in_data): one radio-control frame per
// transfer, holding a battery sample and the throttle and light pulse widths.
// Result channel (out_valid, out_stall, out_data): exactly one result per
// frame, in frame order: PWM on-time, drive direction, lights and the battery
// indicator and low-supply state after that frame.
// Configuration: an APB-style write/read port, eight registers at byte
// addresses 0, 4, ... 28; write them only while no frame is in flight.
// A frame's result moves from the input register into the result register
// when that one is free. Throughput: one frame per cycle while out_stall is low,
// set by the single pass of compare and shift logic between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more frame if it is empty; only then does in_stall rise.
// Reset (rst_n low, synchronous) empties both registers, loads the register
// defaults and clears the battery, blink and held PWM state.
module rc_throttle_motor_drive_top
  import rctmd_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHECK = 8,
  parameter int unsigned GAIN_SHIFT        = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  bat_stat_t bat;
  drv_res_t  drv;

  logic s1_valid_r;
  logic s1_valid_nxt;
  in_t  s1_data_r;
  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;
  logic out_adv;
  logic fire;
  logic in_take;

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r.pwm_on_time     <= drv.pwm;
      out_data_r.drive_forward   <= drv.fwd;
      out_data_r.drive_reverse   <= drv.rev;
      out_data_r.lamp_on         <= drv.lights;
      out_data_r.green_indicator <= bat.green;
      out_data_r.red_indicator   <= bat.red;
      out_data_r.supply_low_flag <= bat.supply_low;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rctmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rctmd_battery #(
    .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK)
  ) u_battery (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (s1_data_r.battery_sample),
    .cfg    (cfg),
    .stat   (bat)
  );

  rctmd_drive #(
    .GAIN_SHIFT (GAIN_SHIFT)
  ) u_drive (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .throttle_width (s1_data_r.throttle_width),
    .light_width    (s1_data_r.light_width),
    .supply_low     (bat.supply_low),
    .cfg            (cfg),
    .res            (drv)
  );

endmodule

/* rtl/rctmd_checker.sv */
`include "rc_throttle_motor_drive_top_defines.svh"

module rctmd_checker
  import rctmd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays put until it is transferred.
  `RCTMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // The motor is never driven both ways at once.
  `RCTMD_ASSERT_NOW(a_dir_excl, out_valid, !(out_data.drive_forward && out_data.drive_reverse))

  // A low supply always cuts the drive.
  `RCTMD_ASSERT_NOW(a_low_no_drive, out_valid && out_data.supply_low_flag,
    !out_data.drive_forward && !out_data.drive_reverse)

  // Green and red indicators are never lit together.
  `RCTMD_ASSERT_NOW(a_ind_excl, out_valid,
    !(out_data.green_indicator && out_data.red_indicator))

endmodule

bind rc_throttle_motor_drive_top rctmd_checker u_rctmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/rc_drive_checker.sv */
module rc_drive_checker
  import rctmd_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHECK = 8,
  parameter int unsigned GAIN_SHIFT        = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                error_count,
  output int                results_owed
);

  cfg_t               cfg;
  logic [BSUM_W-1:0]  bat_sum;
  logic [4:0]         group_fill;
  logic               supply_low;
  logic               green;
  logic               red;
  logic [BLINK_W-1:0] blink;
  logic [PWM_W-1:0]   held_pwm;
  out_t               frame_results_q[$];

  // Advances the drive state by one frame and returns the result it produces.
  function automatic out_t drive_frame(in_t f);
    out_t        r;
    int unsigned mag;
    logic        ahead;
    r = '0;
    // The battery group is classified before the throttle, so a supply change
    // already gates this frame's drive.
    bat_sum    = bat_sum + f.battery_sample;
    group_fill = group_fill + 5'd1;
    if (group_fill >= SAMPLES_PER_CHECK) begin
      if (bat_sum > cfg.battery_high_sum) begin
        green      = ~green;
        red        = 1'b0;
        supply_low = 1'b0;
      end else if (bat_sum > cfg.battery_ok_sum) begin
        green      = 1'b1;
        red        = 1'b0;
        supply_low = 1'b0;
      end else if (bat_sum > cfg.battery_low_sum) begin
        green = 1'b0;
        red   = 1'b1;
      end else begin
        green      = 1'b0;
        red        = ~red;
        supply_low = 1'b1;
      end
      bat_sum    = '0;
      group_fill = '0;
    end
    if (f.throttle_width != '0 && !supply_low) begin
      ahead = f.throttle_width > cfg.throttle_center;
      mag   = ahead ? 32'(f.throttle_width - cfg.throttle_center)
                    : 32'(cfg.throttle_center - f.throttle_width);
      mag   = mag << GAIN_SHIFT;
      if (mag > cfg.pwm_limit) begin
        mag = 32'(cfg.pwm_limit);
      end
      held_pwm = mag[PWM_W-1:0];
      if (held_pwm > cfg.drive_deadband) begin
        if (ahead) begin
          r.drive_forward = 1'b1;
        end else begin
          r.drive_reverse = 1'b1;
        end
      end
    end
    if (f.light_width > cfg.light_valid_width) begin
      r.lamp_on = f.light_width > cfg.light_on_width;
    end else begin
      blink     = blink + 1'b1;
      r.lamp_on = blink == '0;
    end
    r.pwm_on_time     = held_pwm;
    r.green_indicator = green;
    r.red_indicator   = red;
    r.supply_low_flag = supply_low;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    reg_idx_t idx;
    out_t     want;
    if (!rst_n) begin
      cfg.throttle_center   = RST_THROTTLE_CENTER;
      cfg.drive_deadband    = RST_DRIVE_DEADBAND;
      cfg.pwm_limit         = RST_PWM_LIMIT;
      cfg.light_on_width    = RST_LIGHT_ON_WIDTH;
      cfg.light_valid_width = RST_LIGHT_VALID_WIDTH;
      cfg.battery_high_sum  = RST_BATTERY_HIGH_SUM;
      cfg.battery_ok_sum    = RST_BATTERY_OK_SUM;
      cfg.battery_low_sum   = RST_BATTERY_LOW_SUM;
      bat_sum      = '0;
      group_fill   = '0;
      supply_low   = 1'b0;
      green        = 1'b0;
      red          = 1'b0;
      blink        = '0;
      held_pwm     = '0;
      frame_results_q.delete();
      results_owed = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr >> 2);
        case (idx)
          REG_THROTTLE_CENTER:   cfg.throttle_center   = pwdata[WIDTH_W-1:0];
          REG_DRIVE_DEADBAND:    cfg.drive_deadband    = pwdata[PWM_W-1:0];
          REG_PWM_LIMIT:         cfg.pwm_limit         = pwdata[PWM_W-1:0];
          REG_LIGHT_ON_WIDTH:    cfg.light_on_width    = pwdata[WIDTH_W-1:0];
          REG_LIGHT_VALID_WIDTH: cfg.light_valid_width = pwdata[WIDTH_W-1:0];
          REG_BATTERY_HIGH_SUM:  cfg.battery_high_sum  = pwdata[BSUM_W-1:0];
          REG_BATTERY_OK_SUM:    cfg.battery_ok_sum    = pwdata[BSUM_W-1:0];
          REG_BATTERY_LOW_SUM:   cfg.battery_low_sum   = pwdata[BSUM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: result transfer with no frame outstanding, expected none, got pwm %0d",
                   $time, out_data.pwm_on_time);
          error_count++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("pwm_on_time", 32'(want.pwm_on_time),
                      32'(out_data.pwm_on_time));
          check_field("drive_forward", 32'(want.drive_forward),
                      32'(out_data.drive_forward));
          check_field("drive_reverse", 32'(want.drive_reverse),
                      32'(out_data.drive_reverse));
          check_field("lamp_on", 32'(want.lamp_on), 32'(out_data.lamp_on));
          check_field("green_indicator", 32'(want.green_indicator),
                      32'(out_data.green_indicator));
          check_field("red_indicator", 32'(want.red_indicator),
                      32'(out_data.red_indicator));
          check_field("supply_low_flag", 32'(want.supply_low_flag),
                      32'(out_data.supply_low_flag));
        end
      end
      if (in_valid && !in_stall) begin
        frame_results_q.push_back(drive_frame(in_data));
      end
      results_owed = frame_results_q.size();
    end
  end

endmodule

/* bench/rc_throttle_motor_drive_top_tb.sv */
module rc_throttle_motor_drive_top_tb;
  import rctmd_pkg::*;

  localparam int GROUP          = 8;
  localparam int GAIN           = 5;
  localparam int PHASES         = 6;
  localparam int PHASE_FRAMES   = 270;
  localparam int DIRECTED       = 24;
  localparam int QUIET_LIMIT    = 5000;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_t               in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic              in_stall;
  logic              out_valid;
  out_t              out_data;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int   error_count;
  int   results_owed;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   quiet_cycles = 0;
  int   frames_sent  = 0;
  int   bat_band     = 0;
  cfg_t knobs;

  // Throttle and light widths of the directed frames, around the reset
  // center, deadband and light thresholds.
  int unsigned thr_seq[DIRECTED] = '{0, 1500, 8191, 1, 1631, 1632, 1369, 1368,
                                     1632, 1368, 8191, 1, 2000, 1000, 1500, 1632,
                                     1632, 1368, 1500, 8191, 1, 0, 1631, 1369};
  int unsigned lw_seq[DIRECTED]  = '{0, 800, 801, 1300, 1301, 8191, 8191, 0,
                                     1301, 0, 799, 1, 8191, 1300, 801, 0,
                                     1301, 0, 1, 8191, 800, 1300, 0, 1301};

  rc_throttle_motor_drive_top dut (.*);

  rc_drive_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .error_count(error_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= $urandom_range(99) < rx_stall_pct;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rc_throttle_motor_drive_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t s;
    case (p)
      0: begin
        s.throttle_center   = RST_THROTTLE_CENTER;
        s.drive_deadband    = RST_DRIVE_DEADBAND;
        s.pwm_limit         = RST_PWM_LIMIT;
        s.light_on_width    = RST_LIGHT_ON_WIDTH;
        s.light_valid_width = RST_LIGHT_VALID_WIDTH;
        s.battery_high_sum  = RST_BATTERY_HIGH_SUM;
        s.battery_ok_sum    = RST_BATTERY_OK_SUM;
        s.battery_low_sum   = RST_BATTERY_LOW_SUM;
      end
      2: begin
        s.throttle_center   = 13'd8191;
        s.drive_deadband    = 15'd32766;
        s.pwm_limit         = 15'd32767;
        s.light_on_width    = 13'd8191;
        s.light_valid_width = 13'd8190;
        s.battery_high_sum  = 14'd16383;
        s.battery_ok_sum    = 14'd16383;
        s.battery_low_sum   = 14'd0;
      end
      3: s = '0;
      4: begin
        // Thresholds deliberately out of order in both the battery and the
        // light channel.
        s                   = '0;
        s.throttle_center   = WIDTH_W'($urandom_range(8191, 1));
        s.pwm_limit         = '1;
        s.light_on_width    = 13'd100;
        s.light_valid_width = 13'd4000;
        s.battery_high_sum  = BSUM_W'($urandom_range(3800, 3000));
        s.battery_ok_sum    = BSUM_W'($urandom_range(4500, 4000));
        s.battery_low_sum   = BSUM_W'($urandom_range(5000, 4600));
      end
      default: begin
        s.throttle_center   = WIDTH_W'($urandom_range(2000, 1000));
        s.drive_deadband    = PWM_W'($urandom_range(8000, 0));
        s.pwm_limit         = PWM_W'($urandom_range(20000, 4000));
        s.light_on_width    = WIDTH_W'($urandom_range(2000, 900));
        s.light_valid_width = WIDTH_W'($urandom_range(1200, 200));
        s.battery_high_sum  = BSUM_W'($urandom_range(6000, 4000));
        s.battery_ok_sum    = BSUM_W'($urandom_range(s.battery_high_sum, 3500));
        s.battery_low_sum   = BSUM_W'($urandom_range(s.battery_ok_sum, 2500));
      end
    endcase
    return s;
  endfunction

  // Battery samples are drawn per group of frames so that group sums land
  // near the current thresholds for three of the six band picks.
  function automatic in_t random_frame();
    in_t f;
    int  v;
    int  pick;
    int  span;
    if (frames_sent % GROUP == 0) begin
      bat_band = $urandom_range(5);
    end
    case (bat_band)
      0:       v = knobs.battery_high_sum / GROUP;
      1:       v = knobs.battery_ok_sum / GROUP;
      2:       v = knobs.battery_low_sum / GROUP;
      3:       v = $urandom_range(1) ? 1023 : 0;
      default: v = $urandom_range(1023);
    endcase
    f.battery_sample = SAMPLE_W'(clamp(v + int'($urandom_range(4)) - 2, 1023));

    pick = $urandom_range(99);
    if (pick < 8) begin
      v = 0;
    end else if (pick < 16) begin
      v = int'(knobs.throttle_center);
    end else if (pick < 50) begin
      span = int'(($urandom_range(1) ? knobs.drive_deadband : knobs.pwm_limit) >> GAIN)
             + int'($urandom_range(4)) - 2;
      v = $urandom_range(1) ? int'(knobs.throttle_center) + span
                            : int'(knobs.throttle_center) - span;
    end else if (pick < 58) begin
      v = $urandom_range(1) ? 8191 : 1;
    end else begin
      v = $urandom_range(8191);
    end
    f.throttle_width = WIDTH_W'(clamp(v, 8191));

    pick = $urandom_range(99);
    if (pick < 30) begin
      v = $urandom_range(knobs.light_valid_width);
    end else if (pick < 45) begin
      v = int'(knobs.light_valid_width) + int'($urandom_range(2)) - 1;
    end else if (pick < 60) begin
      v = int'(knobs.light_on_width) + int'($urandom_range(2)) - 1;
    end else begin
      v = $urandom_range(8191);
    end
    f.light_width = WIDTH_W'(clamp(v, 8191));
    return f;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_frame(input in_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves psel high so that back-to-back writes go straight to their setup
  // cycle; the caller lowers it after the last one.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_write(REG_THROTTLE_CENTER, CFG_DW'(s.throttle_center));
    cfg_write(REG_DRIVE_DEADBAND, CFG_DW'(s.drive_deadband));
    cfg_write(REG_PWM_LIMIT, CFG_DW'(s.pwm_limit));
    cfg_write(REG_LIGHT_ON_WIDTH, CFG_DW'(s.light_on_width));
    cfg_write(REG_LIGHT_VALID_WIDTH, CFG_DW'(s.light_valid_width));
    cfg_write(REG_BATTERY_HIGH_SUM, CFG_DW'(s.battery_high_sum));
    cfg_write(REG_BATTERY_OK_SUM, CFG_DW'(s.battery_ok_sum));
    cfg_write(REG_BATTERY_LOW_SUM, CFG_DW'(s.battery_low_sum));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    knobs = s;
  endtask

  initial begin
    in_t f;
    int  era;
    tx_idle_pct  = 14;
    rx_stall_pct = 60;
    knobs        = phase_settings(0);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full groups at the top and bottom sample, then one in the good band.
    for (int i = 0; i < DIRECTED; i++) begin
      f.battery_sample = (i < GROUP) ? 10'd1023 : (i < 2 * GROUP) ? 10'd0 : 10'd520;
      f.throttle_width = WIDTH_W'(thr_seq[i]);
      f.light_width    = WIDTH_W'(lw_seq[i]);
      send_frame(f);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_for_results();
        load_settings(phase_settings(p));
      end
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        era = (p * PHASE_FRAMES + k) * 3 / (PHASES * PHASE_FRAMES);
        tx_idle_pct  = (era == 0) ? 14 : (era == 1) ? 60 : 0;
        rx_stall_pct = (era == 0) ? 60 : (era == 1) ? 14 : 0;
        if (k == PHASE_FRAMES / 2) begin
          wait_for_results();
        end
        send_frame(random_frame());
      end
    end

    wait_for_results();
    if (error_count == 0) begin
      $display("rc_throttle_motor_drive_top_tb: clean");
    end else begin
      $display("rc_throttle_motor_drive_top_tb: errors");
    end
    $finish;
  end

endmodule
